FILE: design/lhp_pkg.sv
`timescale 1ns / 1ps

package lhp_pkg;

    // Buffer framing
    localparam int unsigned PrefixLen  = 16;
    localparam int unsigned MinLength  = PrefixLen + 2;
    localparam int unsigned PosWidth   = 5;
    localparam int unsigned CountWidth = 31;
    localparam int unsigned DataWidth  = 8;

    localparam logic [DataWidth-1:0] NewlineByte = 8'h0A;
    localparam logic [DataWidth-1:0] DigitZero   = 8'h30;
    localparam logic [DataWidth-1:0] DigitNine   = 8'h39;

    // Header parse phases
    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2,
        PH_FAIL   = 2'd3
    } t_phase;

    // One result: tag flag and layer count
    typedef struct packed {
        logic [CountWidth-1:0] layer_count;
        logic                  is_tagged;
    } t_result;

    // Fixed header prefix, one byte per position
    function automatic logic [DataWidth-1:0] prefix_byte(input logic [3:0] idx);
        logic [DataWidth-1:0] b;
        case (idx)
            4'd0:    b = 8'h4D;
            4'd1:    b = 8'h45;
            4'd2:    b = 8'h4A;
            4'd3:    b = 8'h49;
            4'd4:    b = 8'h4E;
            4'd5:    b = 8'h45;
            4'd6:    b = 8'h4E;
            4'd7:    b = 8'h43;
            4'd8:    b = 8'h7C;
            4'd9:    b = 8'h6C;
            4'd10:   b = 8'h61;
            4'd11:   b = 8'h79;
            4'd12:   b = 8'h65;
            4'd13:   b = 8'h72;
            4'd14:   b = 8'h73;
            default: b = 8'h3D;
        endcase
        return b;
    endfunction

endpackage

FILE: design/lhp_in_reg.sv
`timescale 1ns / 1ps

module lhp_in_reg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [lhp_pkg::DataWidth-1:0]  i_byte,
    input  logic                           i_last,
    input  logic                           i_advance,
    output logic                           o_valid,
    output logic [lhp_pkg::DataWidth-1:0]  o_byte,
    output logic                           o_last
);

    logic                          r_valid;
    logic [lhp_pkg::DataWidth-1:0] r_byte;
    logic                          r_last;

    // Slot is free when empty or when the held request moves on this cycle
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
            r_last <= i_last;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

FILE: design/lhp_parse.sv
`timescale 1ns / 1ps

module lhp_parse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [lhp_pkg::DataWidth-1:0] i_byte,
    input  logic                          i_last,
    output lhp_pkg::t_result              o_result
);

    localparam logic [lhp_pkg::PosWidth-1:0] PosSat =
        lhp_pkg::PosWidth'(lhp_pkg::MinLength);
    localparam logic [lhp_pkg::PosWidth-1:0] PosLastPrefix =
        lhp_pkg::PosWidth'(lhp_pkg::PrefixLen - 1);
    localparam int unsigned ProdWidth = lhp_pkg::CountWidth + 4;

    lhp_pkg::t_phase                 r_phase, n_phase;
    logic [lhp_pkg::PosWidth-1:0]    r_pos, n_pos;
    logic [lhp_pkg::CountWidth-1:0]  r_acc, n_acc;
    logic                            r_ovf, n_ovf;
    logic                            r_dig, n_dig;

    logic                            is_digit;
    logic [ProdWidth-1:0]            prod;

    assign is_digit = (i_byte >= lhp_pkg::DigitZero) && (i_byte <= lhp_pkg::DigitNine);

    // acc * 10 + digit as two shifts and adds
    assign prod = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0}
                + ProdWidth'(i_byte - lhp_pkg::DigitZero);

    // Next state for the current byte
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_ovf   = r_ovf;
        n_dig   = r_dig;
        n_pos   = (r_pos < PosSat) ? r_pos + 1'b1 : r_pos;
        unique case (r_phase)
            lhp_pkg::PH_PREFIX: begin
                if (i_byte != lhp_pkg::prefix_byte(r_pos[3:0])) begin
                    n_phase = lhp_pkg::PH_FAIL;
                end else if (r_pos == PosLastPrefix) begin
                    n_phase = lhp_pkg::PH_DIGITS;
                end
            end
            lhp_pkg::PH_DIGITS: begin
                if (i_byte == lhp_pkg::NewlineByte) begin
                    n_phase = lhp_pkg::PH_DONE;
                end else if (is_digit) begin
                    n_dig = 1'b1;
                    if (!r_ovf) begin
                        // Anything above 31 bits overflows
                        if (prod[ProdWidth-1:lhp_pkg::CountWidth] != '0) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_acc = prod[lhp_pkg::CountWidth-1:0];
                        end
                    end
                end else begin
                    n_phase = lhp_pkg::PH_FAIL;
                end
            end
            lhp_pkg::PH_DONE,
            lhp_pkg::PH_FAIL: begin
            end
            default: begin
            end
        endcase
    end

    // Result seen on the last byte of a buffer
    always_comb begin
        o_result.is_tagged   = (n_phase == lhp_pkg::PH_DONE) && (n_pos >= PosSat);
        o_result.layer_count = (o_result.is_tagged && n_dig && !n_ovf) ? n_acc : '0;
    end

    // State registers; the last byte restarts for the next buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lhp_pkg::PH_PREFIX;
            r_pos   <= '0;
            r_acc   <= '0;
            r_ovf   <= 1'b0;
            r_dig   <= 1'b0;
        end else if (i_fire) begin
            if (i_last) begin
                r_phase <= lhp_pkg::PH_PREFIX;
                r_pos   <= '0;
                r_acc   <= '0;
                r_ovf   <= 1'b0;
                r_dig   <= 1'b0;
            end else begin
                r_phase <= n_phase;
                r_pos   <= n_pos;
                r_acc   <= n_acc;
                r_ovf   <= n_ovf;
                r_dig   <= n_dig;
            end
        end
    end

endmodule

FILE: design/lhp_out_reg.sv
`timescale 1ns / 1ps

module lhp_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  lhp_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_valid,
    output lhp_pkg::t_result o_result
);

    logic             r_valid;
    lhp_pkg::t_result r_result;

    // Room for a new result when empty or being drained
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: design/layer_header_parser_top.sv
`timescale 1ns / 1ps
// A last byte passes through the input register, and its result is then held in the result
// register until it is read.
// Throughput: one byte per cycle, save where a last byte waits as below; the times-ten accumulate is combinational.
// A last byte waits in the input register only while a previous result is unread.
// Reset (synchronous, active low) empties both registers and restarts header parsing.

module layer_header_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,    // [7:0] data_byte
    input  logic        i_s_axis_tlast,    // last_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata     // [0] is_tagged, [31:1] layer_count
);

    logic                          in_valid;
    logic [lhp_pkg::DataWidth-1:0] in_byte;
    logic                          in_last;
    logic                          out_free;
    logic                          advance;
    lhp_pkg::t_result              step_result;
    lhp_pkg::t_result              out_result;

    // Held byte moves on unless it needs a busy result slot
    assign advance = in_valid && (!in_last || out_free);

    lhp_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_byte    (i_s_axis_tdata),
        .i_last    (i_s_axis_tlast),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_byte    (in_byte),
        .o_last    (in_last)
    );

    lhp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_byte   (in_byte),
        .i_last   (in_last),
        .o_result (step_result)
    );

    lhp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && in_last),
        .i_result (step_result),
        .i_ready  (i_m_axis_tready),
        .o_free   (out_free),
        .o_valid  (o_m_axis_tvalid),
        .o_result (out_result)
    );

    assign o_m_axis_tdata = {out_result.layer_count, out_result.is_tagged};

endmodule

FILE: tb/layer_header_parser_checker.sv
`timescale 1ns / 1ps

module layer_header_parser_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_verdict_count,
    output int          o_tagged_count
);

    // Header prefix, position 0 in the lowest byte
    localparam logic [127:0] HeaderPrefix = 128'h3D73_7265_7961_6C7C_434E_454E_494A_454D;
    localparam logic [lhp_pkg::CountWidth-1:0] CountMax = '1;
    localparam int ReportLimit = 10;

    // Predicted parser state
    logic [lhp_pkg::PosWidth-1:0]   seen_bytes;
    lhp_pkg::t_phase                phase;
    logic [lhp_pkg::CountWidth-1:0] layers;
    logic                           layers_ovf;
    logic                           any_digit;

    lhp_pkg::t_result               header_verdicts_q[$];
    lhp_pkg::t_result               oldest;
    logic [lhp_pkg::CountWidth-1:0] got_count;
    logic                           got_tag;

    int fail_count    = 0;
    int verdict_count = 0;
    int tagged_count  = 0;
    int pending_count = 0;

    assign o_fail_count    = fail_count;
    assign o_pending       = pending_count;
    assign o_verdict_count = verdict_count;
    assign o_tagged_count  = tagged_count;

    task automatic clear_parse();
        seen_bytes = '0;
        phase      = lhp_pkg::PH_PREFIX;
        layers     = '0;
        layers_ovf = 1'b0;
        any_digit  = 1'b0;
    endtask

    // Advance the header parse by one byte; on the last byte queue the verdict
    task automatic parse_header_byte(input logic [7:0] data, input logic last);
        longint unsigned  scaled;
        lhp_pkg::t_result verdict;
        case (phase)
            lhp_pkg::PH_PREFIX: begin
                if (data != HeaderPrefix[8*seen_bytes[3:0] +: 8]) begin
                    phase = lhp_pkg::PH_FAIL;
                end else if (seen_bytes == lhp_pkg::PrefixLen - 1) begin
                    phase = lhp_pkg::PH_DIGITS;
                end
            end
            lhp_pkg::PH_DIGITS: begin
                if (data == lhp_pkg::NewlineByte) begin
                    phase = lhp_pkg::PH_DONE;
                end else if (data >= lhp_pkg::DigitZero && data <= lhp_pkg::DigitNine) begin
                    any_digit = 1'b1;
                    // accumulation freezes once the value passes the 31-bit max
                    if (!layers_ovf) begin
                        scaled = 64'(layers) * 64'd10 + 64'(data) - 64'(lhp_pkg::DigitZero);
                        if (scaled > 64'(CountMax)) begin
                            layers_ovf = 1'b1;
                        end else begin
                            layers = scaled[lhp_pkg::CountWidth-1:0];
                        end
                    end
                end else begin
                    phase = lhp_pkg::PH_FAIL;
                end
            end
            default: ;
        endcase

        if (seen_bytes < lhp_pkg::MinLength) begin
            seen_bytes = seen_bytes + 1'b1;
        end

        if (last) begin
            verdict.is_tagged   = (phase == lhp_pkg::PH_DONE) &&
                                  (seen_bytes >= lhp_pkg::MinLength);
            verdict.layer_count = (verdict.is_tagged && any_digit && !layers_ovf) ? layers : '0;
            header_verdicts_q   = {header_verdicts_q, verdict};
            clear_parse();
        end
    endtask

    // Compare results first: a verdict leaving now belongs to an older buffer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got_tag   = i_m_tdata[0];
                got_count = i_m_tdata[31:1];
                verdict_count++;
                if (got_tag) tagged_count++;
                if (header_verdicts_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= ReportLimit) begin
                        $display("unexpected verdict: tagged=%0b count=%0d", got_tag, got_count);
                    end
                end else begin
                    oldest = header_verdicts_q.pop_front();
                    if (got_tag != oldest.is_tagged || got_count != oldest.layer_count) begin
                        fail_count++;
                        if (fail_count <= ReportLimit) begin
                            $display({"verdict mismatch: expected tagged=%0b count=%0d,",
                                      " got tagged=%0b count=%0d"},
                                     oldest.is_tagged, oldest.layer_count, got_tag, got_count);
                        end
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                parse_header_byte(i_s_tdata, i_s_tlast);
            end
        end
        pending_count = header_verdicts_q.size();
    end

endmodule

FILE: tb/tb_layer_header_parser_top.sv
`timescale 1ns / 1ps

module tb_layer_header_parser_top;

    localparam int CycleLimit   = 200000;
    localparam int PhaseBytes   = 130;
    localparam int PhaseBuffers = 5;
    localparam int DrainCycles  = 16;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    int fail_count;
    int pending;
    int verdict_count;
    int tagged_count;

    int idle_pct     = 0;
    int stall_pct    = 0;
    int bytes_sent   = 0;
    int buffers_sent = 0;
    int cycle_count  = 0;

    logic [7:0] frame_q[$];

    always #1 clk = ~clk;

    layer_header_parser_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    layer_header_parser_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_s_tlast       (s_tlast),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_verdict_count (verdict_count),
        .o_tagged_count  (tagged_count)
    );

    // Result side back-pressure
    always @(negedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("timeout after %0d cycles, %0d verdicts outstanding", cycle_count, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Append one byte to the buffer under construction
    task automatic add_byte(input logic [7:0] b);
        frame_q = {frame_q, b};
    endtask

    // Push the queued buffer one request per byte, last flag on the final byte
    task automatic send_frame();
        for (int k = 0; k < frame_q.size(); k++) begin
            @(negedge clk);
            while ($urandom_range(0, 99) < idle_pct) begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= frame_q[k];
            s_tlast  <= (k == frame_q.size() - 1);
            do @(posedge clk); while (!s_tready);
            bytes_sent++;
        end
        buffers_sent++;
        frame_q.delete();
    endtask

    task automatic push_prefix();
        for (int k = 0; k < lhp_pkg::PrefixLen; k++) begin
            add_byte(lhp_pkg::prefix_byte(k[3:0]));
        end
    endtask

    task automatic push_text(input string txt);
        for (int k = 0; k < txt.len(); k++) begin
            add_byte(txt[k]);
        end
    endtask

    // Trailing bytes after the header: reach the minimum length, then up to four more
    task automatic pad_frame();
        while (frame_q.size() < lhp_pkg::MinLength) begin
            add_byte(8'($urandom_range(0, 255)));
        end
        repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 255)));
    endtask

    initial begin
        int         kind;
        int         cut;
        int         pos;
        string      digits;
        logic [7:0] junk;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: single-byte buffers and the empty number at minimum length
        add_byte(8'hFF);
        send_frame();
        add_byte(8'h00);
        send_frame();
        push_prefix();
        add_byte(lhp_pkg::NewlineByte);
        add_byte(8'h80);
        send_frame();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 50; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 50; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase
            while (bytes_sent < (ph + 1) * PhaseBytes ||
                   buffers_sent < (ph + 1) * PhaseBuffers) begin
                kind = $urandom_range(0, 99);
                if (kind < 90) begin
                    push_prefix();
                    case ($urandom_range(0, 7))
                        0: digits = "";
                        1: digits = $sformatf("%0d", $urandom_range(0, 9));
                        2: digits = $sformatf("%0d", $urandom_range(0, 99999));
                        3: digits = $sformatf("%0d", $urandom & 32'h7FFF_FFFF);
                        4: digits = "2147483647";
                        5: digits = $sformatf("%0d", 64'd2147483648 + $urandom_range(0, 1000));
                        6: digits = {"000", $sformatf("%0d", $urandom_range(0, 999))};
                        default: begin
                            digits = "";
                            repeat ($urandom_range(11, 18)) begin
                                digits = {digits, $sformatf("%0d", $urandom_range(0, 9))};
                            end
                        end
                    endcase
                    push_text(digits);

                    if (kind < 50) begin
                        // well-formed
                        add_byte(lhp_pkg::NewlineByte);
                        pad_frame();
                    end else if (kind < 60) begin
                        // short buffer: complete header at 17 bytes, or cut early
                        if ($urandom_range(0, 1)) begin
                            while (frame_q.size() > lhp_pkg::PrefixLen) begin
                                frame_q.delete(frame_q.size() - 1);
                            end
                            add_byte(lhp_pkg::NewlineByte);
                        end else begin
                            add_byte(lhp_pkg::NewlineByte);
                            cut = $urandom_range(1, lhp_pkg::MinLength - 1);
                            while (frame_q.size() > cut) frame_q.delete(frame_q.size() - 1);
                        end
                    end else if (kind < 70) begin
                        // ends without a newline
                        push_text($sformatf("%0d", $urandom_range(0, 99)));
                    end else if (kind < 80) begin
                        // stray byte among the digits
                        do junk = 8'($urandom_range(0, 255));
                        while ((junk >= lhp_pkg::DigitZero && junk <= lhp_pkg::DigitNine) ||
                               junk == lhp_pkg::NewlineByte);
                        add_byte(junk);
                        push_text($sformatf("%0d", $urandom_range(0, 9)));
                        add_byte(lhp_pkg::NewlineByte);
                        pad_frame();
                    end else begin
                        // one prefix byte damaged
                        add_byte(lhp_pkg::NewlineByte);
                        pad_frame();
                        pos = $urandom_range(0, lhp_pkg::PrefixLen - 1);
                        frame_q[pos] = frame_q[pos] ^ 8'($urandom_range(1, 255));
                    end
                end else begin
                    // noise
                    repeat ($urandom_range(1, 30)) add_byte(8'($urandom_range(0, 255)));
                end
                send_frame();
            end
        end

        @(negedge clk);
        s_tvalid  <= 1'b0;
        stall_pct = 0;
        while (pending != 0) @(negedge clk);
        repeat (DrainCycles) @(negedge clk);

        $display("%0d bytes in %0d buffers sent across four idle/back-pressure mixes;",
                 bytes_sent, buffers_sent);
        $display("%0d verdicts checked, %0d of them tagged, %0d failures.",
                 verdict_count, tagged_count, fail_count);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/lhp_pkg.sv
design/lhp_in_reg.sv
design/lhp_parse.sv
design/lhp_out_reg.sv
design/layer_header_parser_top.sv
tb/layer_header_parser_checker.sv
tb/tb_layer_header_parser_top.sv
